// ===== design/dvf_pkg.sv =====
package dvf_pkg;

	// Default field widths
	localparam int PRESSURE_WIDTH_DEF = 27;
	localparam int SPOOL_WIDTH_DEF    = 16;

	// Fixed widths of registers, results and internal fractions
	localparam int COEF_W    = 32;
	localparam int LIMIT_W   = 26;
	localparam int DZONE_W   = 15;
	localparam int FLOW_W    = 32;
	localparam int FRAC_W    = 32;
	localparam int QUO_W     = 32;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FLOW_COEF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAM_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd2;

	// Register reset values
	localparam logic [COEF_W-1:0]  COEF_RESET  = 32'd14011597;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 26'd200000;
	localparam logic [DZONE_W-1:0] DZONE_RESET = 15'd0;

	typedef enum logic [1:0] {
		VS_SHUT   = 2'd0,
		VS_FEED_A = 2'd1,
		VS_FEED_B = 2'd2
	} valve_state_t;

	// Radicand width: pressure magnitude or laminar limit, scaled by 2^32, made even
	function automatic int rad_width(int pw);
		int wp;
		int wl;
		wp = ((pw + 34) / 2) * 2;
		wl = ((LIMIT_W + FRAC_W + 1) / 2) * 2;
		return (wp > wl) ? wp : wl;
	endfunction

endpackage

// ===== design/dvf_sqrt_pipe.sv =====
module dvf_sqrt_pipe #(
	parameter int RAD_W = 60,
	parameter int LANES = 3,
	parameter int TAG_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [TAG_W-1:0]       in_tag,
	input  logic [RAD_W-1:0]       in_rad [LANES],
	output logic                   out_valid,
	output logic [TAG_W-1:0]       out_tag,
	output logic [RAD_W/2-1:0]     out_root [LANES]
);

	localparam int N = RAD_W / 2;

	logic [N+1:0]       rem_s  [1:N][LANES];
	logic [N-1:0]       root_s [1:N][LANES];
	logic [RAD_W-1:0]   rad_s  [1:N][LANES];
	logic [TAG_W-1:0]   tag_s  [1:N];
	logic [N:1]         vld_s;

	// One root bit per stage, restoring form
	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N+1:0]     rem_p  [LANES];
		logic [N-1:0]     root_p [LANES];
		logic [RAD_W-1:0] rad_p  [LANES];
		logic             vld_p;
		logic [TAG_W-1:0] tag_p;

		if (k == 0) begin : g_first
			assign vld_p = in_valid;
			assign tag_p = in_tag;
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign rem_p[l]  = '0;
				assign root_p[l] = '0;
				assign rad_p[l]  = in_rad[l];
			end
		end else begin : g_next
			assign vld_p = vld_s[k];
			assign tag_p = tag_s[k];
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign rem_p[l]  = rem_s[k][l];
				assign root_p[l] = root_s[k][l];
				assign rad_p[l]  = rad_s[k][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			tag_s[k+1] <= tag_p;
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [N+1:0] rem_sh;
			logic [N+1:0] trial;
			logic         ge;

			always_comb begin
				rem_sh = {rem_p[l][N-1:0], rad_p[l][RAD_W-1 -: 2]};
				trial  = {root_p[l], 2'b01};
				ge     = (rem_sh >= trial);
			end

			always_ff @(posedge clk) begin
				rem_s[k+1][l]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[k+1][l] <= {root_p[l][N-2:0], ge};
				rad_s[k+1][l]  <= {rad_p[l][RAD_W-3:0], 2'b00};
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_tag   = tag_s[N];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign out_root[l] = root_s[N][l];
	end

endmodule

// ===== design/dvf_div_pipe.sv =====
module dvf_div_pipe #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 30,
	parameter int QW    = 32,
	parameter int LANES = 2,
	parameter int TAG_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [TAG_W-1:0]     in_tag,
	input  logic [NUM_W-1:0]     in_num [LANES],
	input  logic [DEN_W-1:0]     in_den,
	output logic                 out_valid,
	output logic [TAG_W-1:0]     out_tag,
	output logic [QW-1:0]        out_quo [LANES]
);

	logic [DEN_W:0]     rem_s [1:QW][LANES];
	logic [QW-1:0]      quo_s [1:QW][LANES];
	logic [DEN_W-1:0]   den_s [1:QW];
	logic [TAG_W-1:0]   tag_s [1:QW];
	logic [QW:1]        vld_s;

	// One quotient bit per stage; numerator sits below the divisor
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DEN_W:0]   rem_p [LANES];
		logic [QW-1:0]    quo_p [LANES];
		logic [DEN_W-1:0] den_p;
		logic             vld_p;
		logic [TAG_W-1:0] tag_p;

		if (k == 0) begin : g_first
			assign vld_p = in_valid;
			assign tag_p = in_tag;
			assign den_p = in_den;
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign rem_p[l] = (DEN_W+1)'(in_num[l]);
				assign quo_p[l] = '0;
			end
		end else begin : g_next
			assign vld_p = vld_s[k];
			assign tag_p = tag_s[k];
			assign den_p = den_s[k];
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign rem_p[l] = rem_s[k][l];
				assign quo_p[l] = quo_s[k][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			tag_s[k+1] <= tag_p;
			den_s[k+1] <= den_p;
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DEN_W:0] rem_sh;
			logic           ge;

			always_comb begin
				rem_sh = {rem_p[l][DEN_W-1:0], 1'b0};
				ge     = (rem_sh >= {1'b0, den_p});
			end

			always_ff @(posedge clk) begin
				rem_s[k+1][l] <= ge ? (rem_sh - {1'b0, den_p}) : rem_sh;
				quo_s[k+1][l] <= {quo_p[l][QW-2:0], ge};
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_tag   = tag_s[QW];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign out_quo[l] = quo_s[QW][l];
	end

endmodule

// ===== design/dvf_flow_out.sv =====
module dvf_flow_out #(
	parameter int SW = 16,
	parameter int GW = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [SW-1:0]                    mag_u,
	input  logic [GW-1:0]                    g_a,
	input  logic [GW-1:0]                    g_b,
	input  logic                             neg_a,
	input  logic                             neg_b,
	input  dvf_pkg::valve_state_t            state,
	input  logic [dvf_pkg::COEF_W-1:0]       coef,
	output logic                             done,
	output logic [dvf_pkg::FLOW_W-1:0]       flow_a,
	output logic [dvf_pkg::FLOW_W-1:0]       flow_b,
	output dvf_pkg::valve_state_t            valve_state
);

	import dvf_pkg::*;

	localparam int MW    = COEF_W + SW;
	localparam int ML    = MW / 2;
	localparam int MH    = MW - ML;
	localparam int SUM_W = MW + GW + 1;
	localparam int FS    = FRAC_W + SW - 1;
	localparam int QW    = SUM_W - FS;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic [MW-1:0]      m_s1;
	logic [GW-1:0]      ga_s1, gb_s1;
	logic               na_s1, nb_s1, na_s2, nb_s2, na_s3, nb_s3;
	valve_state_t       st_s1, st_s2, st_s3, st_s4;
	logic [ML+GW-1:0]   pla_s2, plb_s2;
	logic [MH+GW-1:0]   pha_s2, phb_s2;
	logic [SUM_W-1:0]   suma_s3, sumb_s3;
	logic [FLOW_W-1:0]  fa_s4, fb_s4;

	// Clamp the rounded magnitude to the signed range, apply the sign
	function automatic logic [FLOW_W-1:0] finish(input logic [SUM_W-1:0] sum,
			input logic neg);
		logic [QW-1:0] q;
		logic [QW-1:0] lim;
		logic [QW-1:0] sat;
		q   = sum[SUM_W-1:FS];
		lim = neg ? QW'(33'h1_0000_0000 >> 1) : QW'(33'h0_7FFF_FFFF);
		sat = (q > lim) ? lim : q;
		return neg ? (FLOW_W'(0) - sat[FLOW_W-1:0]) : sat[FLOW_W-1:0];
	endfunction

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Coefficient times spool, then partial products with the gain, then rounded sum, then clamp
	always_ff @(posedge clk) begin
		m_s1    <= MW'(coef) * MW'(mag_u);
		ga_s1   <= g_a;
		gb_s1   <= g_b;
		na_s1   <= neg_a;
		nb_s1   <= neg_b;
		st_s1   <= state;

		pla_s2  <= (ML+GW)'(m_s1[ML-1:0]) * (ML+GW)'(ga_s1);
		pha_s2  <= (MH+GW)'(m_s1[MW-1:ML]) * (MH+GW)'(ga_s1);
		plb_s2  <= (ML+GW)'(m_s1[ML-1:0]) * (ML+GW)'(gb_s1);
		phb_s2  <= (MH+GW)'(m_s1[MW-1:ML]) * (MH+GW)'(gb_s1);
		na_s2   <= na_s1;
		nb_s2   <= nb_s1;
		st_s2   <= st_s1;

		suma_s3 <= (SUM_W'(pha_s2) << ML) + SUM_W'(pla_s2) + (SUM_W'(1) << (FS - 1));
		sumb_s3 <= (SUM_W'(phb_s2) << ML) + SUM_W'(plb_s2) + (SUM_W'(1) << (FS - 1));
		na_s3   <= na_s2;
		nb_s3   <= nb_s2;
		st_s3   <= st_s2;

		fa_s4   <= (st_s3 == VS_SHUT) ? '0 : finish(suma_s3, na_s3);
		fb_s4   <= (st_s3 == VS_SHUT) ? '0 : finish(sumb_s3, nb_s3);
		st_s4   <= st_s3;
	end

	assign done        = vld_s4;
	assign flow_a      = fa_s4;
	assign flow_b      = fb_s4;
	assign valve_state = st_s4;

endmodule

// ===== design/directional_valve_flow_unit.sv =====
// Directional valve flow unit: one valve operating point in, two chamber flows out.
// A new item is taken in every clock cycle (busy stays low) and its result appears
// on flow_a, flow_b and valve_state with done high for one cycle. Each item is
// registered in the front stage and then passes through the bit-per-stage square
// root pipe, the bit-per-stage divider for the linear regime and the four-stage
// gain multiply and clamp. Results cannot be held off: take them in the done cycle.
// Change registers only while no item is in flight.
module directional_valve_flow_unit #(
	parameter int PRESSURE_WIDTH = dvf_pkg::PRESSURE_WIDTH_DEF,
	parameter int SPOOL_WIDTH    = dvf_pkg::SPOOL_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [SPOOL_WIDTH-1:0]    spool_position,
	input  logic signed [PRESSURE_WIDTH-1:0] pressure_a,
	input  logic signed [PRESSURE_WIDTH-1:0] pressure_b,
	input  logic signed [PRESSURE_WIDTH-1:0] supply_pressure,
	input  logic signed [PRESSURE_WIDTH-1:0] tank_pressure,
	output logic                             done,
	output logic signed [dvf_pkg::FLOW_W-1:0] flow_a,
	output logic signed [dvf_pkg::FLOW_W-1:0] flow_b,
	output logic [1:0]                       valve_state,
	input  logic                             cfg_we,
	input  logic [dvf_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [dvf_pkg::COEF_W-1:0]       cfg_wdata
);

	import dvf_pkg::*;

	localparam int SW     = SPOOL_WIDTH;
	localparam int DP_W   = PRESSURE_WIDTH + 1;
	localparam int RAD_W  = rad_width(PRESSURE_WIDTH);
	localparam int ROOT_W = RAD_W / 2;
	localparam int G_W    = (ROOT_W > QUO_W) ? ROOT_W : QUO_W;
	localparam int CMP_W  = ((SW > DZONE_W + 1) ? SW : DZONE_W + 1) + 1;
	localparam int LC_W   = (DP_W > LIMIT_W) ? DP_W : LIMIT_W;
	localparam int TAG1_W = SW + 6 + 2 * LIMIT_W;
	localparam int TAG2_W = SW + 6 + 2 * ROOT_W;

	logic [COEF_W-1:0]  coef_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [DZONE_W-1:0] dzone_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= COEF_RESET;
			limit_q <= LIMIT_RESET;
			dzone_q <= DZONE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_FLOW_COEF: coef_q  <= cfg_wdata;
				CFG_LAM_LIMIT: limit_q <= cfg_wdata[LIMIT_W-1:0];
				CFG_DEAD_ZONE: dzone_q <= cfg_wdata[DZONE_W-1:0];
				default:       ;
			endcase
		end
	end

	// Front stage: valve direction, pressure drops, magnitudes and regime
	logic signed [CMP_W-1:0] u_c, dz_c;
	logic signed [DP_W-1:0]  pa_x, pb_x, ps_x, pt_x, dp_a, dp_b;
	logic [DP_W-1:0]         mag_a, mag_b;
	logic [LC_W-1:0]         mag_a_x, mag_b_x, lim_x;
	logic [SW-1:0]           mag_u;
	valve_state_t            state_c;
	logic                    take;

	assign take = start && !busy;
	assign busy = 1'b0;

	always_comb begin
		u_c  = CMP_W'(spool_position);
		dz_c = signed'(CMP_W'(dzone_q));
		pa_x = DP_W'(pressure_a);
		pb_x = DP_W'(pressure_b);
		ps_x = DP_W'(supply_pressure);
		pt_x = DP_W'(tank_pressure);
		priority if (u_c >= dz_c) begin
			state_c = VS_FEED_A;
		end else if (u_c <= -dz_c) begin
			state_c = VS_FEED_B;
		end else begin
			state_c = VS_SHUT;
		end
		if (state_c == VS_FEED_B) begin
			dp_a = pa_x - pt_x;
			dp_b = ps_x - pb_x;
		end else begin
			dp_a = ps_x - pa_x;
			dp_b = pb_x - pt_x;
		end
		mag_a   = dp_a[DP_W-1] ? (DP_W'(0) - dp_a) : dp_a;
		mag_b   = dp_b[DP_W-1] ? (DP_W'(0) - dp_b) : dp_b;
		mag_u   = spool_position[SW-1] ? (SW'(0) - spool_position) : spool_position;
		mag_a_x = LC_W'(mag_a);
		mag_b_x = LC_W'(mag_b);
		lim_x   = LC_W'(limit_q);
	end

	logic                 vld_s1;
	logic [SW-1:0]        magu_s1;
	logic                 nega_s1, negb_s1, lina_s1, linb_s1;
	valve_state_t         st_s1;
	logic [DP_W-1:0]      maga_s1, magb_s1;
	logic [LIMIT_W-1:0]   numa_s1, numb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		magu_s1 <= mag_u;
		nega_s1 <= spool_position[SW-1] ^ dp_a[DP_W-1];
		negb_s1 <= spool_position[SW-1] ^ dp_b[DP_W-1];
		lina_s1 <= (mag_a_x < lim_x);
		linb_s1 <= (mag_b_x < lim_x);
		st_s1   <= state_c;
		maga_s1 <= mag_a;
		magb_s1 <= mag_b;
		numa_s1 <= mag_a_x[LIMIT_W-1:0];
		numb_s1 <= mag_b_x[LIMIT_W-1:0];
	end

	// Square roots of both drops and of the laminar limit, each radicand scaled by 2^32
	logic [RAD_W-1:0]  rad [3];
	logic [ROOT_W-1:0] root [3];
	logic [TAG1_W-1:0] tag1_in, tag1_out;
	logic              vld_sq;

	assign rad[0]  = RAD_W'(maga_s1) << FRAC_W;
	assign rad[1]  = RAD_W'(magb_s1) << FRAC_W;
	assign rad[2]  = RAD_W'(limit_q) << FRAC_W;
	assign tag1_in = {magu_s1, nega_s1, negb_s1, lina_s1, linb_s1, st_s1, numa_s1, numb_s1};

	dvf_sqrt_pipe #(
		.RAD_W (RAD_W),
		.LANES (3),
		.TAG_W (TAG1_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_tag    (tag1_in),
		.in_rad    (rad),
		.out_valid (vld_sq),
		.out_tag   (tag1_out),
		.out_root  (root)
	);

	// Linear regime: drop scaled by 2^32 over the root of the limit
	logic [SW-1:0]      magu_q;
	logic               nega_q, negb_q, lina_q, linb_q;
	logic [1:0]         st_q;
	logic [LIMIT_W-1:0] num [2];
	logic [QUO_W-1:0]   quo [2];
	logic [TAG2_W-1:0]  tag2_in, tag2_out;
	logic               vld_dv;

	assign {magu_q, nega_q, negb_q, lina_q, linb_q, st_q, num[0], num[1]} = tag1_out;
	assign tag2_in = {magu_q, nega_q, negb_q, lina_q, linb_q, st_q, root[0], root[1]};

	dvf_div_pipe #(
		.NUM_W (LIMIT_W),
		.DEN_W (ROOT_W),
		.QW    (QUO_W),
		.LANES (2),
		.TAG_W (TAG2_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_sq),
		.in_tag    (tag2_in),
		.in_num    (num),
		.in_den    (root[2]),
		.out_valid (vld_dv),
		.out_tag   (tag2_out),
		.out_quo   (quo)
	);

	// Pick the regime per lane and scale by gain and spool
	logic [SW-1:0]     magu_d;
	logic              nega_d, negb_d, lina_d, linb_d;
	logic [1:0]        st_d;
	logic [ROOT_W-1:0] roota_d, rootb_d;
	logic [G_W-1:0]    g_a, g_b;
	valve_state_t      vs_out;

	assign {magu_d, nega_d, negb_d, lina_d, linb_d, st_d, roota_d, rootb_d} = tag2_out;
	assign g_a = lina_d ? G_W'(quo[0]) : G_W'(roota_d);
	assign g_b = linb_d ? G_W'(quo[1]) : G_W'(rootb_d);

	dvf_flow_out #(
		.SW (SW),
		.GW (G_W)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (vld_dv),
		.mag_u       (magu_d),
		.g_a         (g_a),
		.g_b         (g_b),
		.neg_a       (nega_d),
		.neg_b       (negb_d),
		.state       (valve_state_t'(st_d)),
		.coef        (coef_q),
		.done        (done),
		.flow_a      (flow_a),
		.flow_b      (flow_b),
		.valve_state (vs_out)
	);

	assign valve_state = vs_out;

endmodule
